@@ rtl/core/flba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flba_pkg: shared types and constants of the free-list buffer allocator
// Holds the command and status codes and the fixed field widths.
// ----------------------------------------------------------------------------
package flba_pkg;

  // Fixed widths of the command and result fields.
  localparam int unsigned ENTRY_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CFG_W   = 11;

  // Pool size after reset, and the size selected by a write of zero.
  localparam int unsigned RESET_POOL_SIZE   = 1024;
  localparam int unsigned DEFAULT_POOL_SIZE = 1000;

  // Command kinds.
  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_FOREIGN    = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } status_e;

endpackage
`default_nettype wire

@@ rtl/core/flba_link_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flba_link_ram: entry store of the allocator
// One write port and one read port; the read word is registered, so read
// data shows in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module flba_link_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 11,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/free_list_buffer_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_buffer_allocator: fixed-size buffer pool with a LIFO free list
// Hands out entry indices on acquire and takes them back on release.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (kind_i, entry_index_i) is taken at a rising edge with
//   start high and busy low. busy is then high for one cycle while the
//   entry word is read from the RAM and written back. The result word
//   (status_o, granted_index_o, used_count_o) is shown for exactly one cycle
//   under result_strobe_o, in the cycle after busy. A new command may be
//   taken in that same cycle; no new command is taken while busy, since the
//   RAM read of the link/in-use word must come before its write back.
//   The receiver cannot stall: each result must be taken in its cycle.
//   The configuration channel (cfg_valid_i, cfg_ready_o, cfg_pool_size_i)
//   writes pool_size and reinitializes the pool; write it only while idle.
//   Reset sets pool_size to 1024 (capped at POOL_DEPTH) with all entries
//   free. There is no clearing pass: a count of never-issued entries stands
//   in for the initial links and in-use bits, so the block is ready at once.
// ----------------------------------------------------------------------------
module free_list_buffer_allocator import flba_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind_i,
  input  wire logic [ENTRY_W-1:0] entry_index_i,
  // Configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CFG_W-1:0]   cfg_pool_size_i,
  // Result channel
  output logic                    result_strobe_o,
  output logic [1:0]              status_o,
  output logic [ENTRY_W-1:0]      granted_index_o,
  output logic [COUNT_W-1:0]      used_count_o
);

  localparam int unsigned IdxW   = $clog2(POOL_DEPTH);
  localparam int unsigned CntW   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SzW    = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int unsigned WordW  = IdxW + 1;
  localparam int unsigned DefEff = (DEFAULT_POOL_SIZE > POOL_DEPTH) ?
                                   POOL_DEPTH : DEFAULT_POOL_SIZE;
  localparam int unsigned RstEff = (RESET_POOL_SIZE > POOL_DEPTH) ?
                                   POOL_DEPTH : RESET_POOL_SIZE;

  // Pool state.
  logic [CntW-1:0] eff_q;      // effective pool size
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] fresh_q, fresh_d;  // entries 0..fresh-1 never issued
  logic [CntW-1:0] cnt_q, cnt_d;

  // Command being processed.
  logic            busy_q;
  kind_e           kind_q;
  logic [SzW-1:0]  idx_q;

  // Result register.
  logic            res_vld_q;
  status_e         status_q, status_d;
  logic [ENTRY_W-1:0] granted_q, granted_d;
  logic [COUNT_W-1:0] used_q;

  // RAM port signals.
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic accept;
  logic cfg_we;

  assign accept      = start & ~busy_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Effective size of a written pool_size: zero selects the default,
  // anything beyond the store saturates to its depth.
  logic [SzW-1:0]  cfg_size_w;
  logic [CntW-1:0] cfg_eff;
  logic [CntW-1:0] cfg_top;

  assign cfg_size_w = SzW'(cfg_pool_size_i);

  always_comb begin
    if (cfg_pool_size_i == '0) begin
      cfg_eff = CntW'(DefEff);
    end else if (cfg_size_w > SzW'(POOL_DEPTH)) begin
      cfg_eff = CntW'(POOL_DEPTH);
    end else begin
      cfg_eff = cfg_size_w[CntW-1:0];
    end
  end

  assign cfg_top = cfg_eff - CntW'(1);

  // Read address: the entry to release, or the free-list head on acquire.
  logic [SzW-1:0] in_idx_w;

  assign in_idx_w  = SzW'(entry_index_i);
  assign ram_re    = accept;
  assign ram_raddr = (kind_e'(kind_i) == KIND_RELEASE) ? in_idx_w[IdxW-1:0] : head_q;

  flba_link_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read-modify-write of the entry word in the cycle after acceptance.
  logic            rd_in_use;
  logic [IdxW-1:0] rd_link;
  logic            head_fresh;
  logic            idx_fresh;
  logic [IdxW-1:0] next_head;
  logic [SzW-1:0]  head_w;

  assign rd_in_use  = ram_rdata[IdxW];
  assign rd_link    = ram_rdata[IdxW-1:0];
  assign head_w     = SzW'(head_q);
  assign head_fresh = head_w < SzW'(fresh_q);
  assign idx_fresh  = idx_q < SzW'(fresh_q);

  // A never-issued entry links to the one below it; entry 0 links to 0.
  always_comb begin
    if (head_fresh) begin
      next_head = (head_q == '0) ? '0 : head_q - IdxW'(1);
    end else begin
      next_head = rd_link;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = {1'b1, next_head};
    head_d    = head_q;
    fresh_d   = fresh_q;
    cnt_d     = cnt_q;
    status_d  = ST_OK;
    granted_d = '0;
    if (busy_q) begin
      if (kind_q == KIND_ACQUIRE) begin
        if (cnt_q >= eff_q) begin
          status_d = ST_EXHAUSTED;
        end else begin
          // Pop the head and mark it in use.
          ram_we    = 1'b1;
          granted_d = head_w[ENTRY_W-1:0];
          head_d    = next_head;
          fresh_d   = head_fresh ? CntW'(head_q) : fresh_q;
          cnt_d     = cnt_q + CntW'(1);
        end
      end else begin
        if (idx_q >= SzW'(eff_q)) begin
          status_d = ST_FOREIGN;
        end else if (idx_fresh || !rd_in_use) begin
          status_d = ST_NOT_IN_USE;
        end else begin
          // Push the entry back on the head of the free list.
          ram_we    = 1'b1;
          ram_waddr = idx_q[IdxW-1:0];
          ram_wdata = {1'b0, head_q};
          head_d    = idx_q[IdxW-1:0];
          cnt_d     = cnt_q - CntW'(1);
        end
      end
    end
  end

  // Pool state registers; a size write reinitializes the pool.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q   <= CntW'(RstEff);
      head_q  <= IdxW'(RstEff - 1);
      fresh_q <= CntW'(RstEff);
      cnt_q   <= '0;
    end else if (cfg_we) begin
      eff_q   <= cfg_eff;
      head_q  <= cfg_top[IdxW-1:0];
      fresh_q <= cfg_eff;
      cnt_q   <= '0;
    end else begin
      head_q  <= head_d;
      fresh_q <= fresh_d;
      cnt_q   <= cnt_d;
    end
  end

  // Command capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= in_idx_w;
    end
  end

  // Result register, shown for one cycle.
  logic [SzW-1:0] cnt_w;

  assign cnt_w = SzW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      used_q    <= cnt_w[COUNT_W-1:0];
    end
  end

  assign busy            = busy_q;
  assign result_strobe_o = res_vld_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign used_count_o    = used_q;

endmodule
`default_nettype wire

@@ rtl/core/flba_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flba_checker: port-level assertions for the buffer allocator
// Checks command timing and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module flba_checker import flba_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_strobe_o,
  input wire logic [1:0]         status_o,
  input wire logic [ENTRY_W-1:0] granted_index_o,
  input wire logic [COUNT_W-1:0] used_count_o
);

  // An accepted command makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A busy cycle is followed by a result in the next cycle, with busy low.
  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy && result_strobe_o)
    else $error("result did not follow the busy cycle");

  // A failed command grants nothing.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o != ST_OK |-> granted_index_o == '0)
    else $error("failed command reported a granted index");

  // An exhausted pool always has entries in use.
  a_exhaust_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o == ST_EXHAUSTED |-> used_count_o != '0)
    else $error("exhausted status with no entries in use");

endmodule

bind free_list_buffer_allocator flba_checker u_flba_checker (.*);
`default_nettype wire

@@ verif/pool_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_result_checker: scoreboard for the free-list buffer allocator
// Watches the command, configuration and result channels. It keeps its own
// copy of the free list, the in-use bits and the used-entry count, works out the
// result word for every accepted command word and compares each result word
// with the oldest expected one.
// ----------------------------------------------------------------------------
module pool_result_checker import flba_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               kind_i,
  input  logic [ENTRY_W-1:0] entry_index_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CFG_W-1:0]   cfg_pool_size_i,
  input  logic               result_strobe_i,
  input  logic [1:0]         status_i,
  input  logic [ENTRY_W-1:0] granted_index_i,
  input  logic [COUNT_W-1:0] used_count_i,
  output int                 mismatch_count_o,
  output int                 pending_words_o
);

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] granted;
    logic [COUNT_W-1:0] used;
  } pool_reply_t;

  // Shadow copy of the pool.
  logic [ENTRY_W-1:0] link_mem [POOL_DEPTH];
  logic               entry_in_use [POOL_DEPTH];
  logic [ENTRY_W-1:0] free_head;
  logic [COUNT_W-1:0] used_entries;
  int unsigned        pool_limit;

  // Result words still owed by the allocator, oldest first.
  pool_reply_t        owed_replies [$];

  // A size write rebuilds the whole free list: size-1 on top, down to 0.
  function automatic void rebuild_pool(input logic [CFG_W-1:0] size);
    int unsigned limit;
    limit = (size == '0) ? DEFAULT_POOL_SIZE : size;
    if (limit > POOL_DEPTH) limit = POOL_DEPTH;
    pool_limit = limit;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      link_mem[i]     = (i == 0) ? '0 : ENTRY_W'(i - 1);
      entry_in_use[i] = 1'b0;
    end
    free_head    = ENTRY_W'(limit - 1);
    used_entries = '0;
  endfunction

  // Applies one command word to the shadow pool and returns its result word.
  function automatic pool_reply_t apply_command(input kind_e kind,
                                                input logic [ENTRY_W-1:0] index);
    pool_reply_t reply;
    reply.status  = ST_OK;
    reply.granted = '0;
    if (kind == KIND_ACQUIRE) begin
      if (used_entries >= pool_limit) begin
        reply.status = ST_EXHAUSTED;
      end else begin
        reply.granted          = free_head;
        free_head              = link_mem[reply.granted];
        entry_in_use[reply.granted] = 1'b1;
        used_entries++;
      end
    end else if (index >= pool_limit) begin
      reply.status = ST_FOREIGN;
    end else if (!entry_in_use[index]) begin
      reply.status = ST_NOT_IN_USE;
    end else begin
      entry_in_use[index] = 1'b0;
      link_mem[index]     = free_head;
      free_head           = index;
      used_entries--;
    end
    reply.used = used_entries;
    return reply;
  endfunction

  // Compare the result word first, since a new command word may be taken in
  // the same cycle as the previous result.
  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t want;
    if (!rst_ni) begin
      rebuild_pool(CFG_W'(RESET_POOL_SIZE));
      owed_replies.delete();
      mismatch_count_o = 0;
      pending_words_o  = 0;
    end else begin
      if (result_strobe_i) begin
        if (owed_replies.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: result word with none expected: status=%0d granted=%0d used=%0d",
                     $time, status_i, granted_index_i, used_count_i);
          mismatch_count_o++;
        end else begin
          want = owed_replies.pop_front();
          if (status_i !== want.status || granted_index_i !== want.granted ||
              used_count_i !== want.used) begin
            if (mismatch_count_o < 10) begin
              $write("%0t: result word mismatch: expected status=%0d granted=%0d used=%0d",
                     $time, want.status, want.granted, want.used);
              $display(", got status=%0d granted=%0d used=%0d",
                       status_i, granted_index_i, used_count_i);
            end
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) rebuild_pool(cfg_pool_size_i);
      if (start_i && !busy_i)
        owed_replies.push_back(apply_command(kind_e'(kind_i), entry_index_i));
      pending_words_o = owed_replies.size();
    end
  end

endmodule

@@ verif/tb_free_list_buffer_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_list_buffer_allocator: testbench of the free-list buffer allocator
// Drives a short directed run over the pool corners, then random acquire and
// release traffic over many pool sizes with varying sender gaps. A separate
// checker predicts every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_free_list_buffer_allocator;
  import flba_pkg::*;

  localparam int unsigned POOL_DEPTH  = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEG_WORDS   = 50;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               kind_i = KIND_ACQUIRE;
  logic [ENTRY_W-1:0] entry_index_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_pool_size_i = '0;
  logic               result_strobe_o;
  logic [1:0]         status_o;
  logic [ENTRY_W-1:0] granted_index_o;
  logic [COUNT_W-1:0] used_count_o;

  int                 mismatch_count;
  int                 pending_words;
  int unsigned        idle_pct = 0;
  int unsigned        pool_limit = RESET_POOL_SIZE;
  int unsigned        cycle_count = 0;

  logic [CFG_W-1:0]   corner_sizes [6] = '{11'd2047, 11'd1, 11'd0, 11'd2, 11'd1024, 11'd1025};

  free_list_buffer_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_pool_size_i(cfg_pool_size_i),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .granted_index_o(granted_index_o),
    .used_count_o   (used_count_o)
  );

  pool_result_checker #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind_i),
    .entry_index_i   (entry_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_pool_size_i (cfg_pool_size_i),
    .result_strobe_i (result_strobe_o),
    .status_i        (status_o),
    .granted_index_i (granted_index_o),
    .used_count_i    (used_count_o),
    .mismatch_count_o(mismatch_count),
    .pending_words_o (pending_words)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_free_list_buffer_allocator: done, errors");
      $finish;
    end
  end

  // Sends one command word and waits until the allocator takes it, then
  // leaves random gaps with noise on the idle fields.
  task automatic send_command(input kind_e kind, input logic [ENTRY_W-1:0] index);
    start         <= 1'b1;
    kind_i        <= kind;
    entry_index_i <= index;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      kind_i        <= 1'($urandom);
      entry_index_i <= ENTRY_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Lowers start and waits until every result word has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes pool_size while the allocator is idle.
  task automatic write_pool_size(input logic [CFG_W-1:0] size);
    wait_idle();
    cfg_valid_i     <= 1'b1;
    cfg_pool_size_i <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    cfg_pool_size_i <= CFG_W'($urandom);
    pool_limit = (size == '0) ? DEFAULT_POOL_SIZE : size;
    if (pool_limit > POOL_DEPTH) pool_limit = POOL_DEPTH;
  endtask

  // Releases often hit recently granted entries near the top of the pool; others
  // pick any index in the pool, a foreign index above it, or a fully random one.
  function automatic logic [ENTRY_W-1:0] pick_release_index();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = (pool_limit < 48) ? pool_limit : 48;
    if (roll < 45) return ENTRY_W'($urandom_range(pool_limit - 1, pool_limit - span));
    if (roll < 75) return ENTRY_W'($urandom_range(pool_limit - 1, 0));
    if (roll < 88 && pool_limit < POOL_DEPTH)
      return ENTRY_W'($urandom_range(POOL_DEPTH - 1, pool_limit));
    return ENTRY_W'($urandom);
  endfunction

  // Random traffic with a given share of acquires.
  task automatic run_segment(input int unsigned words, input int unsigned acquire_pct);
    repeat (words) begin
      if ($urandom_range(99) < acquire_pct)
        send_command(KIND_ACQUIRE, ENTRY_W'($urandom));
      else
        send_command(KIND_RELEASE, pick_release_index());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] size;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset pool: LIFO reuse and double release.
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_ACQUIRE, '1);
    send_command(KIND_RELEASE, 10'd1023);
    send_command(KIND_RELEASE, 10'd1023);
    send_command(KIND_RELEASE, 10'd0);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_RELEASE, 10'd1022);
    send_command(KIND_RELEASE, 10'd1023);

    // Two-entry pool: exhaustion and foreign indexes.
    write_pool_size(11'd2);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_RELEASE, 10'd2);
    send_command(KIND_RELEASE, 10'd1023);
    send_command(KIND_RELEASE, 10'd0);
    send_command(KIND_RELEASE, 10'd1);
    send_command(KIND_ACQUIRE, '0);

    // Zero selects the default size and drops the entry still out.
    write_pool_size(11'd0);
    send_command(KIND_RELEASE, 10'd999);
    send_command(KIND_RELEASE, 10'd1000);
    send_command(KIND_ACQUIRE, '0);

    // An oversized pool saturates to the full depth.
    write_pool_size(11'd2047);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_RELEASE, 10'd1023);

    // One-entry pool.
    write_pool_size(11'd1);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_ACQUIRE, '0);
    send_command(KIND_RELEASE, 10'd0);
    send_command(KIND_RELEASE, 10'd1);

    // Random part: three gap profiles, each over several pool sizes.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 70 : 0;
      for (int seg = 0; seg < 9; seg++) begin
        if (seg < 2)
          size = corner_sizes[phase * 2 + seg];
        else if ($urandom_range(99) < 85)
          size = CFG_W'($urandom_range(40, 1));
        else
          size = CFG_W'($urandom_range(1023, 41));
        write_pool_size(size);
        run_segment(SEG_WORDS, $urandom_range(75, 30));
      end
    end

    wait_idle();
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_free_list_buffer_allocator: done, clean");
    end else begin
      $display("tb_free_list_buffer_allocator: done, errors");
    end
    $finish;
  end

endmodule
